### rtl/llfq_pkg.sv
// Package for the linked-list FIFO queue: sequencer states, operation and
// status codes, and the structs passed between the sequencer and the store.
// Depends on nothing.
package llfq_pkg;

  localparam int DATA_W = 32;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_REMOVED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic data_we;
    logic link_we;
    logic valid_set;
    logic valid_clr;
  } store_ctrl_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  value;
  } result_t;

endpackage

### rtl/llfq_if.sv
// Request and result channel interfaces for the linked-list FIFO queue.
// Depends on llfq_pkg.
interface llfq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic signed [llfq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface llfq_out_if;
  logic                              valid;
  logic                              ready;
  llfq_pkg::status_t                 status;
  logic signed [llfq_pkg::DATA_W-1:0] pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

### rtl/llfq_store.sv
// Entry table of the queue: data and link memories with registered reads,
// plus the per-entry valid flags. Depends on llfq_pkg.
module llfq_store #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  llfq_pkg::store_ctrl_t                ctrl,
  input  logic [$clog2(ENTRIES)-1:0]           wr_addr,
  input  logic [llfq_pkg::DATA_W-1:0]          wr_data,
  input  logic [$clog2(ENTRIES+1)-1:0]         wr_link,
  input  logic [$clog2(ENTRIES)-1:0]           clr_addr,
  input  logic [$clog2(ENTRIES)-1:0]           rd_addr,
  output logic [llfq_pkg::DATA_W-1:0]          rd_data,
  output logic [$clog2(ENTRIES+1)-1:0]         rd_link,
  input  logic [$clog2(ENTRIES)-1:0]           scan_addr,
  output logic                                 scan_free
);
  import llfq_pkg::*;

  localparam int LW = $clog2(ENTRIES+1);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  logic [DATA_W-1:0]  data_mem [ENTRIES];
  logic [LW-1:0]      link_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [DATA_W-1:0]  rd_data_r;
  logic [LW-1:0]      rd_link_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.data_we) begin
      data_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    rd_link_r  <= link_mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctrl.valid_set) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctrl.valid_clr) begin
        valid_r[clr_addr] <= 1'b0;
      end
    end
  end

  // A free entry reads as having no older link.
  assign rd_link   = rd_valid_r ? rd_link_r : NULL_LINK;
  assign rd_data   = rd_data_r;
  assign scan_free = !valid_r[scan_addr];

endmodule

### rtl/llfq_seq.sv
// Sequencer of the queue: scans for a free entry on an add and walks the
// link chain on a remove, one entry per cycle. Depends on llfq_pkg.
module llfq_seq #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [llfq_pkg::DATA_W-1:0]          in_value,
  output logic                                 done_valid,
  input  logic                                 done_ready,
  output llfq_pkg::result_t                    done_res,
  output llfq_pkg::store_ctrl_t                ctrl,
  output logic [$clog2(ENTRIES)-1:0]           wr_addr,
  output logic [llfq_pkg::DATA_W-1:0]          wr_data,
  output logic [$clog2(ENTRIES+1)-1:0]         wr_link,
  output logic [$clog2(ENTRIES)-1:0]           clr_addr,
  output logic [$clog2(ENTRIES)-1:0]           rd_addr,
  input  logic [llfq_pkg::DATA_W-1:0]          rd_data,
  input  logic [$clog2(ENTRIES+1)-1:0]         rd_link,
  output logic [$clog2(ENTRIES)-1:0]           scan_addr,
  input  logic                                 scan_free
);
  import llfq_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES+1);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES-1);

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] push_r, push_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt, cnt_inc;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     prev_r, prev_nxt;
  logic [LW-1:0]     newest_r, newest_nxt;
  result_t           res_r, res_nxt;
  logic              newest_is_idx, link_is_idx, prev_is_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      newest_r <= NULL_LINK;
    end else begin
      state_r  <= state_nxt;
      newest_r <= newest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    push_r <= push_nxt;
    cnt_r  <= cnt_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    res_r  <= res_nxt;
  end

  // The one incrementer serves as scan index on an add and step count on a remove.
  assign cnt_inc       = cnt_r + IW'(1);
  assign newest_is_idx = newest_r < NULL_LINK;
  assign link_is_idx   = rd_link < NULL_LINK;
  assign prev_is_idx   = prev_r < NULL_LINK;
  assign scan_addr     = cnt_r;
  assign clr_addr      = cur_r;
  assign wr_data       = push_r;
  assign done_res      = res_r;

  always_comb begin
    state_nxt  = state_r;
    push_nxt   = push_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    newest_nxt = newest_r;
    res_nxt    = res_r;
    ctrl       = '0;
    wr_addr    = cnt_r;
    wr_link    = newest_r;
    rd_addr    = newest_r[IW-1:0];
    in_ready   = 1'b0;
    done_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          push_nxt = in_value;
          cnt_nxt  = '0;
          if (in_op == OP_ADD) begin
            state_nxt = S_SCAN;
          end else if (!newest_is_idx) begin
            res_nxt   = '{status: ST_EMPTY, value: '0};
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = newest_r[IW-1:0];
            prev_nxt  = NULL_LINK;
            state_nxt = S_WALK;
          end
        end
      end
      S_SCAN: begin
        if (scan_free) begin
          ctrl.data_we   = 1'b1;
          ctrl.link_we   = 1'b1;
          ctrl.valid_set = 1'b1;
          newest_nxt     = LW'(cnt_r);
          res_nxt        = '{status: ST_ADDED, value: '0};
          state_nxt      = S_DONE;
        end else if (cnt_r == LAST_IDX) begin
          res_nxt   = '{status: ST_FULL, value: '0};
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      S_WALK: begin
        if (link_is_idx && (cnt_r != LAST_IDX)) begin
          prev_nxt = LW'(cur_r);
          cur_nxt  = rd_link[IW-1:0];
          rd_addr  = rd_link[IW-1:0];
          cnt_nxt  = cnt_inc;
        end else begin
          // The current entry is the oldest: free it and cut the link to it.
          ctrl.valid_clr = 1'b1;
          if (prev_is_idx) begin
            ctrl.link_we = 1'b1;
            wr_addr      = prev_r[IW-1:0];
            wr_link      = NULL_LINK;
          end else begin
            newest_nxt = NULL_LINK;
          end
          res_nxt   = '{status: ST_REMOVED, value: rd_data};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/linked_list_fifo_queue_core.sv
// Top level of the linked-list FIFO queue: sequencer, entry table and the
// result register. Depends on llfq_pkg, llfq_if, llfq_seq and llfq_store.
//
// Usage: each request on in_req either adds push_value to the queue
// (operation 0) or removes the oldest value (operation 1). Every request
// gives exactly one result on out_rsp: status 0 added, 1 full, 2 removed
// with the value in pop_value, 3 empty. pop_value is zero unless removed.
// The queue lives in a table of ENTRIES entries linked from newest to
// oldest; one request is worked on at a time and in_req.ready is high
// only while the sequencer is idle.
// Timing: an add scans the valid flags one entry per cycle up to the
// lowest free one, or through the whole table when it is full. A remove
// follows one link per cycle through the registered link-memory read,
// and needs no walk when the queue is empty. The result is registered in
// the sequencer's done state and then shown from the output register.
// Stalls: the result waits in an output register; the next request is
// accepted and worked on meanwhile, and its result is held back in the
// sequencer until the register frees up.
// Reset (synchronous, rst_n low) empties the queue at once: every entry
// is marked free and no result is pending.
module linked_list_fifo_queue_core #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  llfq_in_if.sink           in_req,
  llfq_out_if.source        out_rsp
);
  import llfq_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES+1);

  store_ctrl_t       ctrl;
  logic [IW-1:0]     wr_addr, clr_addr, rd_addr, scan_addr;
  logic [DATA_W-1:0] wr_data, rd_data;
  logic [LW-1:0]     wr_link, rd_link;
  logic              scan_free;
  logic              done_valid, done_ready;
  result_t           done_res;
  logic              out_valid_r;
  result_t           out_res_r;

  llfq_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_op      (in_req.operation),
    .in_value   (in_req.push_value),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_res   (done_res),
    .ctrl       (ctrl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .wr_link    (wr_link),
    .clr_addr   (clr_addr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rd_link    (rd_link),
    .scan_addr  (scan_addr),
    .scan_free  (scan_free)
  );

  llfq_store #(.ENTRIES(ENTRIES)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .wr_link    (wr_link),
    .clr_addr   (clr_addr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rd_link    (rd_link),
    .scan_addr  (scan_addr),
    .scan_free  (scan_free)
  );

  // The result register takes a new result when empty or being drained.
  assign done_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_res_r <= done_res;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_res_r.status;
  assign out_rsp.pop_value = out_res_r.value;

endmodule

### rtl/llfq_checker.sv
// Port-level checks for the linked-list FIFO queue, bound to the top level.
// Depends on llfq_pkg and linked_list_fifo_queue_core.
module llfq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input llfq_pkg::status_t            status,
  input logic [llfq_pkg::DATA_W-1:0]  pop_value
);
  import llfq_pkg::*;

  // A pending result is never dropped before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Only a removal carries a value.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_REMOVED) |-> pop_value == '0)
    else $error("nonzero value on a result that removed nothing");

  // Ready drops after a request is accepted, since the sequencer leaves its idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind linked_list_fifo_queue_core llfq_checker u_llfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .status    (out_rsp.status),
  .pop_value (out_rsp.pop_value)
);

### tb/linked_list_fifo_queue_core_test.sv
// Self-checking testbench for linked_list_fifo_queue_core: random and directed add/remove
// requests, checked against a table-and-link model of the queue kept alongside the block.
// Depends on llfq_pkg, llfq_if and the RTL of the core.
module linked_list_fifo_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import llfq_pkg::*;

  localparam int ENTRIES         = 16;
  localparam int NULL_SLOT       = ENTRIES;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 2 * ENTRIES + 8;

  logic clk = 1'b0;
  logic rst_n;

  llfq_in_if  in_req ();
  llfq_out_if out_rsp ();

  linked_list_fifo_queue_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // Two-phase clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the entry table. Every slot holds a value, a used flag and the
  // index of the next older slot; NULL_SLOT marks the end of the chain and an
  // empty queue when it sits in newest_slot.
  logic signed [DATA_W-1:0] slot_value [ENTRIES];
  bit                       slot_used  [ENTRIES];
  int                       slot_older [ENTRIES];
  int                       newest_slot;

  // Results the block still owes, oldest first.
  result_t pending_results [$];

  int error_count;
  int results_seen;

  // Set for the last part of the run: both sides then run without idling.
  bit steady_flow;

  // Each increment asks the result side for one long hold-off.
  int hold_off_requests;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
    error_count++;
  endtask

  function automatic void clear_queue_model();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_value[i] = '0;
      slot_used[i]  = 1'b0;
      slot_older[i] = NULL_SLOT;
    end
    newest_slot = NULL_SLOT;
  endfunction

  // Applies one request to the model and returns the result it must give.
  function automatic result_t apply_queue_op(input logic op,
                                             input logic signed [DATA_W-1:0] value);
    result_t outcome;
    int      slot;
    int      cur;
    int      prev;
    outcome.status = ST_ADDED;
    outcome.value  = '0;
    if (op == OP_ADD) begin
      // The new value goes into the lowest-numbered free slot.
      slot = NULL_SLOT;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!slot_used[i]) slot = i;
      end
      if (slot == NULL_SLOT) begin
        outcome.status = ST_FULL;
      end else begin
        slot_value[slot] = value;
        slot_used[slot]  = 1'b1;
        slot_older[slot] = newest_slot;
        newest_slot      = slot;
      end
    end else if (newest_slot == NULL_SLOT) begin
      outcome.status = ST_EMPTY;
    end else begin
      // Follow the links from the newest slot down to the oldest one.
      cur  = newest_slot;
      prev = NULL_SLOT;
      for (int steps = 1; steps < ENTRIES; steps++) begin
        if (slot_older[cur] == NULL_SLOT) break;
        prev = cur;
        cur  = slot_older[cur];
      end
      slot_used[cur]  = 1'b0;
      slot_older[cur] = NULL_SLOT;
      if (prev == NULL_SLOT) newest_slot = NULL_SLOT;
      else slot_older[prev] = NULL_SLOT;
      outcome.status = ST_REMOVED;
      outcome.value  = slot_value[cur];
    end
    return outcome;
  endfunction

  // Mostly random words, with the signed extremes and the all-zero and
  // all-one patterns mixed in.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] word;
    case ($urandom_range(0, 15))
      0:       word = {1'b1, {(DATA_W-1){1'b0}}};
      1:       word = {1'b0, {(DATA_W-1){1'b1}}};
      2:       word = '0;
      3:       word = '1;
      default: word = $urandom;
    endcase
    return word;
  endfunction

  // Sends one request. Called and returns at a falling edge; valid stays high
  // when the next request follows right away. The expected result is queued
  // at the rising edge where the handshake completes.
  task automatic send_request(input logic op, input logic signed [DATA_W-1:0] value);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_req.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_req.valid      = 1'b1;
    in_req.operation  = op;
    in_req.push_value = value;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    pending_results.push_back(apply_queue_op(op, value));
    @(negedge clk);
  endtask

  // Sends a run of requests where add_percent sets the share of adds.
  task automatic send_mixed(input int count, input int add_percent);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < add_percent) ? OP_ADD : OP_REMOVE;
      send_request(op, pick_value());
    end
  endtask

  // A remove straight after reset finds the queue empty.
  task automatic test_remove_from_empty();
    send_request(OP_REMOVE, pick_value());
  endtask

  // Fills every slot, starting with the signed extremes, both alternating bit patterns,
  // all-zero and all-one, then tries one add more than the table can hold.
  task automatic test_fill_to_full();
    send_request(OP_ADD, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(OP_ADD, {1'b0, {(DATA_W-1){1'b1}}});
    send_request(OP_ADD, {(DATA_W/2){2'b01}});
    send_request(OP_ADD, {(DATA_W/2){2'b10}});
    send_request(OP_ADD, '0);
    send_request(OP_ADD, '1);
    for (int i = 6; i < ENTRIES; i++) send_request(OP_ADD, pick_value());
    send_request(OP_ADD, pick_value());
  endtask

  // Phases that lean toward filling, draining or holding steady, so the queue
  // keeps swinging between empty and full and freed slots end up scattered
  // across the table.
  task automatic test_mixed_traffic(input int total);
    int sent;
    int phase_len;
    int bias;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       bias = 80;
        1:       bias = 20;
        default: bias = 50;
      endcase
      send_mixed(phase_len, bias);
      sent += phase_len;
    end
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the output register and the sequencer fill up and the input stalls.
  task automatic test_result_backpressure();
    hold_off_requests++;
    send_mixed(40, 50);
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_steady_stream();
    steady_flow = 1'b1;
    send_mixed(80, 80);
    send_mixed(80, 20);
    send_mixed(80, 50);
  endtask

  // Waits out every owed result, then keeps watching for DRAIN_CYCLES to catch strays.
  task automatic finish_run();
    in_req.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result-side ready: random stall bursts, the long hold-off
  // on request, and always ready once the steady part has begun.
  initial begin : drive_result_ready
    int stall_left;
    int hold_off_served;
    stall_left      = 0;
    hold_off_served = 0;
    out_rsp.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_served != hold_off_requests) begin
        hold_off_served = hold_off_requests;
        stall_left      = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_rsp.ready = 1'b0;
        stall_left--;
      end else begin
        out_rsp.ready = 1'b1;
      end
    end
  end

  // Every completed result is matched against the oldest owed one.
  always @(posedge clk) begin : check_results
    result_t owed;
    if (rst_n === 1'b1 && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        owed = pending_results.pop_front();
        if (out_rsp.status !== owed.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_rsp.status, owed.status));
        end
        if (out_rsp.pop_value !== owed.value) begin
          report_mismatch($sformatf("pop_value %h, expected %h",
                                    out_rsp.pop_value, owed.value));
        end
      end
      results_seen++;
    end
  end

  initial begin
    error_count       = 0;
    results_seen      = 0;
    steady_flow       = 1'b0;
    hold_off_requests = 0;
    in_req.valid      = 1'b0;
    in_req.operation  = OP_ADD;
    in_req.push_value = '0;
    clear_queue_model();

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_remove_from_empty();
    test_fill_to_full();
    test_mixed_traffic(1500);
    test_result_backpressure();
    test_steady_stream();
    finish_run();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every request full-scan slow, with
  // the longest gaps and stalls on both sides.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
